// ----- hw/rtl/psdq_pkg.sv -----
// Shared types and constants for the processor-sharing delta queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package psdq_pkg;

  localparam int MAX_SERVERS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WORK_W          = 48;
  localparam int TAG_W           = 16;
  localparam int RATE_W          = 16;
  localparam int SC_W            = 5;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIR_SHARING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_RATE   = 2'd2;

  localparam logic [SC_W-1:0]   SERVER_COUNT_RST = 5'd4;
  localparam logic              FAIR_SHARING_RST = 1'b1;
  localparam logic [RATE_W-1:0] TOTAL_RATE_RST   = 16'd1000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_OVERRUN = 2'd3
  } status_t;

  typedef struct packed {
    logic              func;
    logic [TAG_W-1:0]  task_tag;
    logic [31:0]       task_work;
    logic [WORK_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              next_valid;
    logic [WORK_W-1:0] next_finish_delay;
    logic [TAG_W-1:0]  finished_tag;
  } rsp_t;

  typedef struct packed {
    logic    latch;
    logic    pop;
    logic    mul;
    logic    chg_start;
    logic    chg_apply;
    logic    step;
    logic    insert;
    logic    dly_start;
    logic    dly_take;
    logic    dly_sat;
    logic    dly_zero;
    logic    set_st;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic is_finish;
    logic empty;
    logic full;
    logic overrun;
    logic found;
    logic at_end;
    logic div_done;
    logic rate_zero;
  } sts_t;

endpackage

// ----- hw/rtl/psdq_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for the charge and the delay.
module psdq_div #(
  parameter int NW  = 80,
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [NW-1:0]  quotient,
  output logic           done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q;
  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  dvs;
  logic [CNTW-1:0] cnt;
  logic            running;
  logic [DVW:0]    rem_sh;
  logic [DVW:0]    diff;
  logic            ge;

  assign rem_sh   = {rem, q[NW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q       <= dividend;
        dvs     <= divisor;
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        q   <= {q[NW-2:0], ge};
        rem <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/psdq_dp.sv -----
// Datapath: delta list, task count, charge and delay arithmetic, result register.
// Depends on psdq_pkg and psdq_div.
module psdq_dp
  import psdq_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  req_t              req,
  input  logic [SC_W-1:0]   server_count,
  input  logic              fair_sharing,
  input  logic [RATE_W-1:0] total_rate,
  input  cmd_t              cmd,
  output sts_t              sts,
  output rsp_t              rsp
);

  localparam int IW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW  = $clog2(MAX_SERVERS + 1);
  localparam int QW  = 64 + FRAC_BITS;
  localparam logic [56:0] TOL = 57'((64'd1 << FRAC_BITS) / 1000);
  localparam logic [WORK_W-1:0] MASK = '1;

  req_t              rq;
  logic [CW-1:0]     active;
  logic [WORK_W-1:0] last_update;
  logic [WORK_W-1:0] delta [MAX_SERVERS];
  logic [TAG_W-1:0]  tags  [MAX_SERVERS];
  logic [63:0]       prod;
  logic [CW-1:0]     idx;
  logic [WORK_W-1:0] acc;

  logic [15:0]       div_d;
  logic [WORK_W-1:0] elapsed;
  logic [63:0]       len_wide;
  logic [WORK_W-1:0] len;
  logic [WORK_W-1:0] cur;
  logic [WORK_W:0]   cum;
  logic [WORK_W-1:0] nd;
  logic [56:0]       charge;
  logic [56:0]       head_x;
  logic              over;
  logic [56:0]       excess;
  logic [63:0]       head_prod;
  logic              div_start;
  logic [QW-1:0]     div_num;
  logic [15:0]       div_den;
  logic [QW-1:0]     div_q;
  logic              div_done;
  logic [31:0]       cap;

  // Share divisor: active tasks under fair sharing, else servers; never zero.
  always_comb begin
    div_d = fair_sharing ? 16'(active) : 16'(server_count);
    if (div_d == 16'd0) div_d = 16'd1;
  end

  assign cap      = (32'(server_count) < 32'(MAX_SERVERS)) ? 32'(server_count)
                                                            : 32'(MAX_SERVERS);
  assign elapsed  = (rq.now_time >= last_update) ? rq.now_time - last_update : '0;
  assign len_wide = 64'(rq.task_work) << FRAC_BITS;
  assign len      = (|len_wide[63:WORK_W]) ? MASK : len_wide[WORK_W-1:0];
  assign cur      = delta[idx[IW-1:0]];
  assign cum      = {1'b0, acc} + {1'b0, cur};
  assign nd       = len - acc;

  assign charge = (|div_q[QW-1:56]) ? (57'd1 << 56) : {1'b0, div_q[55:0]};
  assign head_x = 57'(delta[0]);
  assign over   = charge > head_x;
  assign excess = charge - head_x;

  assign head_prod = 64'(delta[0]) * 64'(div_d);

  assign div_start = cmd.chg_start | cmd.dly_start;
  assign div_num   = cmd.chg_start ? {prod, FRAC_BITS'(0)} : QW'(head_prod);
  assign div_den   = cmd.chg_start ? div_d : total_rate;

  psdq_div #(.NW(QW), .DVW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    sts.is_finish = rq.func;
    sts.empty     = (active == '0);
    sts.full      = 32'(active) >= cap;
    sts.overrun   = over && (excess > TOL);
    sts.at_end    = (idx == active);
    sts.found     = (idx < active) && (cum >= {1'b0, len});
    sts.div_done  = div_done;
    sts.rate_zero = (total_rate == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      last_update <= '0;
    end else begin
      if (cmd.pop) begin
        active      <= active - CW'(1);
        last_update <= rq.now_time;
      end else if (cmd.insert) begin
        active      <= active + CW'(1);
        last_update <= rq.now_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rq                <= req;
      idx               <= '0;
      acc               <= '0;
      rsp.status        <= ST_OK;
      rsp.finished_tag  <= '0;
    end
    if (cmd.set_st) rsp.status <= cmd.st;
    if (cmd.mul) prod <= 64'(elapsed) * 64'(total_rate);
    if (cmd.step) begin
      acc <= cum[WORK_W-1:0];
      idx <= idx + CW'(1);
    end
    if (cmd.pop) rsp.finished_tag <= tags[0];
    if (cmd.dly_zero) begin
      rsp.next_valid        <= 1'b0;
      rsp.next_finish_delay <= '0;
    end
    if (cmd.dly_sat) begin
      rsp.next_valid        <= 1'b1;
      rsp.next_finish_delay <= MASK;
    end
    if (cmd.dly_take) begin
      rsp.next_valid        <= 1'b1;
      rsp.next_finish_delay <= (|div_q[QW-1:WORK_W]) ? MASK : div_q[WORK_W-1:0];
    end
  end

  // List entries: each one looks only at its neighbors.
  for (genvar j = 0; j < MAX_SERVERS; j++) begin : g_ent
    always_ff @(posedge clk) begin
      if (cmd.pop) begin
        if (j + 1 < MAX_SERVERS) begin
          delta[j] <= delta[(j + 1) % MAX_SERVERS];
          tags[j]  <= tags[(j + 1) % MAX_SERVERS];
        end
      end else if (cmd.chg_apply && j == 0) begin
        delta[j] <= over ? '0 : delta[j] - charge[WORK_W-1:0];
      end else if (cmd.insert) begin
        if (CW'(j) == idx) begin
          delta[j] <= nd;
          tags[j]  <= rq.task_tag;
        end else if (j > 0 && CW'(j) == idx + CW'(1)) begin
          delta[j] <= delta[(j + MAX_SERVERS - 1) % MAX_SERVERS] - nd;
          tags[j]  <= tags[(j + MAX_SERVERS - 1) % MAX_SERVERS];
        end else if (j > 0 && CW'(j) > idx) begin
          delta[j] <= delta[(j + MAX_SERVERS - 1) % MAX_SERVERS];
          tags[j]  <= tags[(j + MAX_SERVERS - 1) % MAX_SERVERS];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/psdq_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
// Depends on psdq_pkg.
module psdq_ctrl
  import psdq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_MUL, S_CSTART, S_CWAIT, S_CHG,
    S_SEARCH, S_INS, S_DELAY, S_DWAIT, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    cmd.st     = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_finish) begin
          if (sts.empty) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_EMPTY;
          end else begin
            cmd.pop = 1'b1;
          end
          state_next = S_DELAY;
        end else if (sts.full) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
          state_next = S_DELAY;
        end else if (sts.empty) begin
          state_next = S_SEARCH;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CSTART;
      end
      S_CSTART: begin
        cmd.chg_start = 1'b1;
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        if (sts.div_done) state_next = S_CHG;
      end
      S_CHG: begin
        if (sts.overrun) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_OVERRUN;
          state_next = S_DELAY;
        end else begin
          cmd.chg_apply = 1'b1;
          state_next    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.found || sts.at_end) begin
          state_next = S_INS;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_DELAY;
      end
      S_DELAY: begin
        if (sts.empty) begin
          cmd.dly_zero = 1'b1;
          state_next   = S_OUT;
        end else if (sts.rate_zero) begin
          cmd.dly_sat = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.dly_start = 1'b1;
          state_next    = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.dly_take = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/processor_sharing_delta_queue_top.sv -----
// Top level of the processor-sharing delta queue: configuration registers,
// controller and datapath. Depends on psdq_pkg, psdq_ctrl and psdq_dp.
//
// One request is taken when start is high and busy is low. Its result appears
// on rsp for one cycle with done high, and the receiver cannot stall it.
// A finish, or an add refused because the pool is full, goes from the decision
// straight to the delay division. An add to an empty list skips the charge and
// inserts; an add refused for overrun runs the charge division first, and an
// accepted add runs the charge division and the sorted insertion first. The
// shared one-bit-per-cycle divider serves both the work charge and the
// completion delay. The sorted insertion walks the list one entry per cycle.
// An empty finish or a zero rate skips the delay division, so such a request
// finishes sooner. busy drops in the cycle after the strobe.
// Configuration writes are always ready and are meant to happen while busy
// is low.
module processor_sharing_delta_queue_top
  import psdq_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [SC_W-1:0]   server_count;
  logic              fair_sharing;
  logic [RATE_W-1:0] total_rate;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SERVER_COUNT_RST;
      fair_sharing <= FAIR_SHARING_RST;
      total_rate   <= TOTAL_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SERVER_COUNT: server_count <= cfg_data[SC_W-1:0];
        CFG_FAIR_SHARING: fair_sharing <= cfg_data[0];
        CFG_TOTAL_RATE:   total_rate   <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  psdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  psdq_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .server_count (server_count),
    .fair_sharing (fair_sharing),
    .total_rate   (total_rate),
    .cmd          (cmd),
    .sts          (sts),
    .rsp          (rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request taken but block not busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe outside a request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("block stays busy after its result");

  a_empty_delay: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.next_valid |-> rsp.next_finish_delay == '0)
    else $error("delay reported with no running task");

endmodule
